// ===== src/odt_pkg.sv =====
// Package for the observation dedup table: widths, reset values, codes and
// the command and status types shared by the controller and the datapath.
// No dependencies.
package odt_pkg;

  localparam int unsigned TableSlotsDef = 128;
  localparam int unsigned AddrW         = 48;
  localparam int unsigned SigW          = 8;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned ReasonW       = 3;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned ApbAddrW      = 3;

  localparam logic [SigW-1:0]   RssiRiseReset = 8'd6;
  localparam logic [CoordW-1:0] MoveReset     = 32'd2700;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [SigW-1:0]   sig_t;
  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic [0:0] {
    RegRssiRise = 1'b0,
    RegMove     = 1'b1
  } reg_idx_e;

  typedef enum logic [ReasonW-1:0] {
    ReasonFiltered = 3'd0,
    ReasonEmpty    = 3'd1,
    ReasonOther    = 3'd2,
    ReasonRise     = 3'd3,
    ReasonMoved    = 3'd4
  } reason_e;

  typedef struct packed {
    logic rd_en;
    logic eval_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ===== src/odt_if.sv =====
// Handshake channels of the observation dedup table: observation in, result out.
// Depends on odt_pkg.
interface odt_obs_if;
  import odt_pkg::*;
  logic   valid;
  logic   ready;
  addr_t  device_address;
  sig_t   signal_level;
  coord_t latitude;
  coord_t longitude;
  logic   sink_ok;

  modport source (output valid, device_address, signal_level, latitude, longitude, sink_ok,
                  input ready);
  modport sink (input valid, device_address, signal_level, latitude, longitude, sink_ok,
                output ready);
endinterface

interface odt_res_if;
  import odt_pkg::*;
  logic               valid;
  logic               ready;
  logic               log_record;
  logic               append_failed;
  logic [ReasonW-1:0] decision_reason;

  modport source (output valid, log_record, append_failed, decision_reason, input ready);
  modport sink (input valid, log_record, append_failed, decision_reason, output ready);
endinterface

// ===== src/odt_regs.sv =====
// Configuration registers of the observation dedup table behind an APB-style port.
// Depends on odt_pkg.
module odt_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [odt_pkg::ApbAddrW-1:0]   paddr,
  input  logic [odt_pkg::ApbDataW-1:0]   pwdata,
  output logic [odt_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output odt_pkg::sig_t                  rssi_thr_o,
  output odt_pkg::coord_t                move_thr_o
);
  import odt_pkg::*;

  sig_t     rssi_thr_q;
  coord_t   move_thr_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rssi_thr_q <= RssiRiseReset;
      move_thr_q <= MoveReset;
    end else if (wr_en) begin
      case (idx)
        RegRssiRise: rssi_thr_q <= pwdata[SigW-1:0];
        RegMove:     move_thr_q <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegRssiRise: prdata = {{(ApbDataW-SigW){1'b0}}, rssi_thr_q};
      RegMove:     prdata = move_thr_q;
      default:     prdata = '0;
    endcase
  end

  assign rssi_thr_o = rssi_thr_q;
  assign move_thr_o = move_thr_q;

endmodule

// ===== src/odt_ctrl.sv =====
// Controller of the observation dedup table: sequences table read and evaluate.
// Depends on odt_pkg.
module odt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  odt_pkg::dp_status_t status_i,
  output odt_pkg::ctrl_cmd_t  cmd_o
);
  import odt_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEval = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o    = (state_q == StIdle);
  assign cmd_o.rd_en   = in_valid_i && in_ready_o;
  assign cmd_o.eval_en = (state_q == StEval) && !status_i.out_busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.rd_en) state_d = StEval;
      end
      StEval: begin
        if (cmd_o.eval_en) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/odt_dpath.sv =====
// Datapath of the observation dedup table: slot hash, table memory, valid marks,
// decision logic and result register. Depends on odt_pkg.
module odt_dpath #(
  parameter int unsigned TABLE_SLOTS = odt_pkg::TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  odt_pkg::ctrl_cmd_t            cmd_i,
  output odt_pkg::dp_status_t           status_o,
  input  odt_pkg::addr_t                device_address_i,
  input  odt_pkg::sig_t                 signal_level_i,
  input  odt_pkg::coord_t               latitude_i,
  input  odt_pkg::coord_t               longitude_i,
  input  logic                          sink_ok_i,
  input  odt_pkg::sig_t                 rssi_thr_i,
  input  odt_pkg::coord_t               move_thr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          log_record_o,
  output logic                          append_failed_o,
  output logic [odt_pkg::ReasonW-1:0]   decision_reason_o
);
  import odt_pkg::*;

  localparam int unsigned IdxW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  typedef struct packed {
    addr_t  addr;
    sig_t   sig;
    coord_t lat;
    coord_t lon;
  } entry_t;

  entry_t                 mem_q [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_q;

  entry_t         item_q;
  logic           ok_q;
  logic [IdxW-1:0] slot_q;
  entry_t         stored_q;
  logic           hit_valid_q;

  logic            out_valid_q;
  logic            log_q;
  logic            fail_q;
  reason_e         reason_q;

  logic [7:0]      fold;
  logic [15:0]     rem;
  logic [IdxW-1:0] slot;
  entry_t          item_in;
  reason_e         reason;
  logic [SigW-1:0] sig_rise;
  coord_t          lat_diff;
  coord_t          lon_diff;
  logic            do_write;

  always_comb begin
    fold = '0;
    for (int b = 0; b < AddrW / 8; b++) begin
      fold = fold ^ device_address_i[8*b +: 8];
    end
    rem = {8'b0, fold};
    for (int k = 7; k >= 0; k--) begin
      if (rem >= 16'(TABLE_SLOTS << k)) rem = rem - 16'(TABLE_SLOTS << k);
    end
  end

  assign slot    = rem[IdxW-1:0];
  assign item_in = '{addr: device_address_i, sig: signal_level_i,
                     lat: latitude_i, lon: longitude_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      item_q   <= item_in;
      ok_q     <= sink_ok_i;
      slot_q   <= slot;
      stored_q <= mem_q[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_valid_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      hit_valid_q <= valid_q[slot];
    end
  end

  assign sig_rise = item_q.sig - stored_q.sig;
  assign lat_diff = (item_q.lat > stored_q.lat) ? item_q.lat - stored_q.lat
                                                : stored_q.lat - item_q.lat;
  assign lon_diff = (item_q.lon > stored_q.lon) ? item_q.lon - stored_q.lon
                                                : stored_q.lon - item_q.lon;

  always_comb begin
    if (!hit_valid_q) begin
      reason = ReasonEmpty;
    end else if (stored_q.addr != item_q.addr) begin
      reason = ReasonOther;
    end else if (item_q.sig >= stored_q.sig && sig_rise >= rssi_thr_i) begin
      reason = ReasonRise;
    end else if (lat_diff >= move_thr_i || lon_diff >= move_thr_i) begin
      reason = ReasonMoved;
    end else begin
      reason = ReasonFiltered;
    end
  end

  assign do_write = cmd_i.eval_en && (reason != ReasonFiltered) && ok_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[slot_q] <= item_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_write) begin
      valid_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.eval_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_en) begin
      reason_q <= reason;
      log_q    <= (reason != ReasonFiltered) && ok_q;
      fail_q   <= (reason != ReasonFiltered) && !ok_q;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign log_record_o      = log_q;
  assign append_failed_o   = fail_q;
  assign decision_reason_o = reason_q;

endmodule

// ===== src/observation_dedup_table.sv =====
// Observation dedup table: direct-mapped cache that decides whether a radio
// observation is logged. The accepted observation and the stored slot entry are
// registered, then evaluated and written back, and the result is registered.
// A new observation is accepted only after the current one is evaluated, and a
// held result stalls the evaluate step. Reset clears all valid marks and
// restores both thresholds; table contents are left undefined and need no
// clearing pass. Depends on odt_pkg, odt_if.
module observation_dedup_table #(
  parameter int unsigned TABLE_SLOTS = odt_pkg::TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  odt_obs_if.sink                       obs_i,
  odt_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [odt_pkg::ApbAddrW-1:0]  paddr,
  input  logic [odt_pkg::ApbDataW-1:0]  pwdata,
  output logic [odt_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import odt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  sig_t       rssi_thr;
  coord_t     move_thr;

  odt_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .rssi_thr_o (rssi_thr),
    .move_thr_o (move_thr)
  );

  odt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (obs_i.valid),
    .in_ready_o (obs_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  odt_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i             (cmd),
    .status_o          (status),
    .device_address_i  (obs_i.device_address),
    .signal_level_i    (obs_i.signal_level),
    .latitude_i        (obs_i.latitude),
    .longitude_i       (obs_i.longitude),
    .sink_ok_i         (obs_i.sink_ok),
    .rssi_thr_i        (rssi_thr),
    .move_thr_i        (move_thr),
    .out_valid_o       (res_o.valid),
    .out_ready_i       (res_o.ready),
    .log_record_o      (res_o.log_record),
    .append_failed_o   (res_o.append_failed),
    .decision_reason_o (res_o.decision_reason)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for observation_dedup_table: drives observations over the input channel and an
// APB port, predicts each log decision from a shadow table and checks every result transfer.
// Depends on odt_pkg, odt_if and the observation_dedup_table RTL.
module tb;
  import odt_pkg::*;

  localparam int unsigned SLOTS     = TableSlotsDef;
  localparam int unsigned POOL      = 32;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    addr_t  addr;
    sig_t   sig;
    coord_t lat;
    coord_t lon;
    logic   ok;
  } obs_t;

  typedef struct packed {
    logic    logged;
    logic    refused;
    reason_e reason;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  odt_obs_if obs_ch ();
  odt_res_if res_ch ();

  observation_dedup_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .obs_i   (obs_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow table and thresholds
  logic   tbl_valid [SLOTS];
  addr_t  tbl_addr  [SLOTS];
  sig_t   tbl_sig   [SLOTS];
  coord_t tbl_lat   [SLOTS];
  coord_t tbl_lon   [SLOTS];
  sig_t   rise_thr = RssiRiseReset;
  coord_t move_thr = MoveReset;

  obs_t     obs_q[$];
  verdict_t verdict_q[$];

  // recently used devices for well-formed revisits
  addr_t  pool_addr [POOL];
  sig_t   pool_sig  [POOL];
  coord_t pool_lat  [POOL];
  coord_t pool_lon  [POOL];

  int errors       = 0;
  int obs_sent     = 0;
  int results_seen = 0;
  int refusals     = 0;
  int cfg_writes   = 0;
  int reason_hits [5];
  int src_idle_pct = 20;
  int snk_idle_pct = 20;
  int stall_req    = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results outstanding", verdict_q.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic void report(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  function automatic coord_t coord_gap(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void judge_obs(obs_t o);
    logic [7:0]  fold;
    int unsigned slot;
    reason_e     why;
    verdict_t    v;
    fold = o.addr[7:0] ^ o.addr[15:8] ^ o.addr[23:16] ^ o.addr[31:24] ^ o.addr[39:32]
         ^ o.addr[47:40];
    slot = fold % SLOTS;
    if (!tbl_valid[slot]) why = ReasonEmpty;
    else if (tbl_addr[slot] != o.addr) why = ReasonOther;
    else if (o.sig >= tbl_sig[slot] && sig_t'(o.sig - tbl_sig[slot]) >= rise_thr)
      why = ReasonRise;
    else if (coord_gap(o.lat, tbl_lat[slot]) >= move_thr ||
             coord_gap(o.lon, tbl_lon[slot]) >= move_thr)
      why = ReasonMoved;
    else why = ReasonFiltered;
    v.reason  = why;
    v.logged  = (why != ReasonFiltered) && o.ok;
    v.refused = (why != ReasonFiltered) && !o.ok;
    if (v.logged) begin
      tbl_valid[slot] = 1'b1;
      tbl_addr[slot]  = o.addr;
      tbl_sig[slot]   = o.sig;
      tbl_lat[slot]   = o.lat;
      tbl_lon[slot]   = o.lon;
    end
    verdict_q.push_back(v);
  endfunction

  function automatic coord_t nudge(coord_t last);
    coord_t step;
    step = move_thr + coord_t'($urandom_range(0, 2)) - coord_t'(1);
    case ($urandom_range(0, 3))
      0: return last;
      1: return last + step;
      2: return last - step;
      default: return $urandom();
    endcase
  endfunction

  function automatic obs_t draw_obs();
    obs_t o;
    int   k;
    int   s;
    o.ok = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 99) < 8) begin
      o.addr = {16'($urandom()), $urandom()};
      o.sig  = sig_t'($urandom());
      o.lat  = $urandom();
      o.lon  = $urandom();
      return o;
    end
    k = $urandom_range(0, POOL - 1);
    o.addr = pool_addr[k];
    case ($urandom_range(0, 3))
      0: s = int'(pool_sig[k]);
      1: s = int'(pool_sig[k]) + int'(rise_thr) + int'($urandom_range(0, 2)) - 1;
      2: s = int'(pool_sig[k]) - int'($urandom_range(1, 12));
      default: s = int'($urandom_range(0, 255));
    endcase
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    o.sig = sig_t'(s);
    o.lat = nudge(pool_lat[k]);
    o.lon = nudge(pool_lon[k]);
    pool_sig[k] = o.sig;
    pool_lat[k] = o.lat;
    pool_lon[k] = o.lon;
    return o;
  endfunction

  function automatic void add_obs(addr_t a, sig_t s, coord_t la, coord_t lo, logic ok);
    obs_t o;
    o = '{addr: a, sig: s, lat: la, lon: lo, ok: ok};
    obs_q.push_back(o);
  endfunction

  function automatic void add_random(int n);
    for (int i = 0; i < n; i++) obs_q.push_back(draw_obs());
  endfunction

  task automatic settle();
    while (obs_q.size() != 0 || obs_ch.valid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_transfer(reg_idx_e idx, logic wr, logic [31:0] wdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== wdata)
      report($sformatf("register %s read %h, expected %h", idx.name(), prdata, wdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_thresholds(sig_t rise, coord_t move);
    apb_transfer(RegRssiRise, 1'b1, 32'(rise));
    apb_transfer(RegMove, 1'b1, move);
    rise_thr = rise;
    move_thr = move;
    cfg_writes++;
    apb_transfer(RegRssiRise, 1'b0, 32'(rise));
    apb_transfer(RegMove, 1'b0, move);
  endtask

  // driver: offer queued observations, idle in bursts
  obs_t offered;
  int   src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (obs_ch.valid && obs_ch.ready) begin
        judge_obs(offered);
        obs_sent++;
      end
      if (obs_ch.valid && !obs_ch.ready) begin
      end else if (src_gap > 0) begin
        src_gap--;
        obs_ch.valid <= 1'b0;
      end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(1, 10) - 1;
        obs_ch.valid <= 1'b0;
      end else if (obs_q.size() != 0) begin
        offered = obs_q.pop_front();
        obs_ch.valid          <= 1'b1;
        obs_ch.device_address <= offered.addr;
        obs_ch.signal_level   <= offered.sig;
        obs_ch.latitude       <= offered.lat;
        obs_ch.longitude      <= offered.lon;
        obs_ch.sink_ok        <= offered.ok;
      end else begin
        obs_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: check result transfers, stall in bursts and on request
  verdict_t want;
  int snk_gap    = 0;
  int hold_left  = 0;
  int stall_seen = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("unexpected result log=%b fail=%b reason=%0d", res_ch.log_record,
                           res_ch.append_failed, res_ch.decision_reason));
        end else begin
          want = verdict_q.pop_front();
          results_seen++;
          reason_hits[int'(want.reason)]++;
          if (want.refused) refusals++;
          if (res_ch.log_record !== want.logged || res_ch.append_failed !== want.refused ||
              res_ch.decision_reason !== want.reason)
            report($sformatf("result %0d: got log=%b fail=%b reason=%0d, expected %b %b %0d",
                             results_seen, res_ch.log_record, res_ch.append_failed,
                             res_ch.decision_reason, want.logged, want.refused,
                             int'(want.reason)));
        end
      end
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res_ch.ready <= 1'b0;
      end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap = $urandom_range(1, 10) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    addr_t dev_a;
    addr_t dev_b;
    addr_t dev_c;
    addr_t dev_d;
    int    src;
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    obs_ch.valid          = 1'b0;
    obs_ch.device_address = '0;
    obs_ch.signal_level   = '0;
    obs_ch.latitude       = '0;
    obs_ch.longitude      = '0;
    obs_ch.sink_ok        = 1'b0;
    res_ch.ready          = 1'b0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    foreach (reason_hits[i]) reason_hits[i] = 0;
    for (int i = 0; i < POOL; i++) begin
      if (i < 24) begin
        pool_addr[i] = {16'($urandom()), $urandom()};
      end else begin
        // same slot, different address: equal flips in two bytes, or bit 7 of one byte
        src = $urandom_range(0, 23);
        if (i % 2 == 0) pool_addr[i] = pool_addr[src] ^ 48'h0000_0000_0101 * ($urandom_range(1, 255));
        else pool_addr[i] = pool_addr[src] ^ (48'h80 << (8 * $urandom_range(0, 5)));
      end
      pool_sig[i] = sig_t'($urandom());
      pool_lat[i] = $urandom();
      pool_lon[i] = $urandom();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_transfer(RegRssiRise, 1'b0, 32'(RssiRiseReset));
    apb_transfer(RegMove, 1'b0, MoveReset);

    dev_a = 48'h0123_4567_89AB;
    dev_b = dev_a ^ 48'h0000_0000_1010;
    dev_c = dev_a ^ 48'h0000_0000_0080;
    add_obs(dev_a, 100, 1000, 5000, 1'b1);
    add_obs(dev_a, 100, 1000, 5000, 1'b1);
    add_obs(dev_a, 106, 1000, 5000, 1'b1);
    add_obs(dev_a, 111, 1000, 5000, 1'b1);
    add_obs(dev_a, 20, 1000, 5000, 1'b1);
    add_obs(dev_a, 106, 3699, 5000, 1'b1);
    add_obs(dev_a, 106, 3700, 5000, 1'b1);
    add_obs(dev_a, 106, 3700, 2300, 1'b1);
    add_obs(dev_b, 50, 0, 0, 1'b0);
    add_obs(dev_a, 106, 3700, 2300, 1'b1);
    add_obs(dev_c, 7, 1, 1, 1'b1);
    add_obs(dev_b, 9, 9, 9, 1'b1);
    add_obs(dev_b, 9, 9, 9, 1'b1);
    add_obs('1, 255, '1, 0, 1'b0);
    add_obs('1, 255, '1, 0, 1'b1);
    add_obs('0, 0, 0, '1, 1'b1);
    add_obs('0, 0, '1, '1, 1'b1);
    add_obs('0, 255, '1, '1, 1'b1);
    add_obs('0, 255, '1, '1, 1'b1);
    settle();
    add_random(120);
    settle();

    set_thresholds(8'd0, 32'd0);
    add_obs('0, 255, '1, '1, 1'b1);
    add_obs('0, 254, '1, '1, 1'b1);
    add_obs('0, 254, '1, '1, 1'b0);
    add_random(80);
    settle();

    set_thresholds(8'hFF, 32'hFFFF_FFFF);
    dev_d = 48'h5A5A_0F0F_C3C3;
    add_obs(dev_d, 0, 0, 0, 1'b1);
    add_obs(dev_d, 255, 0, 0, 1'b1);
    add_obs(dev_d, 255, '1, 0, 1'b1);
    add_obs(dev_d, 255, 1, 0, 1'b1);
    add_random(80);
    settle();

    set_thresholds(sig_t'($urandom_range(1, 30)), coord_t'($urandom_range(50, 20000)));
    add_random(120);
    stall_req++;
    add_random(60);
    settle();
    src_idle_pct = 0;
    snk_idle_pct = 5;
    add_random(60);
    settle();

    set_thresholds(RssiRiseReset, MoveReset);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    add_random(100);

    while (obs_q.size() != 0 || obs_ch.valid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d observations under %0d threshold settings; %0d refused appends",
             obs_sent, cfg_writes + 1, refusals);
    $display("Reasons seen: filtered %0d, empty %0d, other %0d, rise %0d, moved %0d",
             reason_hits[ReasonFiltered], reason_hits[ReasonEmpty], reason_hits[ReasonOther],
             reason_hits[ReasonRise], reason_hits[ReasonMoved]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/odt_pkg.sv
src/odt_if.sv
src/odt_regs.sv
src/odt_ctrl.sv
src/odt_dpath.sv
src/observation_dedup_table.sv
tb/sv/tb.sv
